// File: rtl/four_digit_segment_scan_defines.svh
// Assertion macros for the four-digit segment scan block.
// Used by rtl modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef FOUR_DIGIT_SEGMENT_SCAN_DEFINES_SVH
`define FOUR_DIGIT_SEGMENT_SCAN_DEFINES_SVH

`ifndef SYNTHESIS
// check gated off while reset is asserted
`define FDSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that must also hold during reset
`define FDSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDSS_ASSERT(lbl, prop, msg)
`define FDSS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/fdss_pkg.sv
// Shared types, constants and decode functions for the segment scan block.
// No dependencies.
package fdss_pkg;

    localparam int NUM_W         = 14;
    localparam int DWELL_W       = 16;
    localparam int EN_W          = 4;
    localparam int SEG_W         = 8;
    localparam int DIG_W         = 4;
    localparam int POS_W         = 2;
    localparam int EXP_W         = 3;
    localparam int MAX_DIGITS    = 4;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = 2;
    localparam int QCNT_W        = 3;

    localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd100;
    localparam logic [DWELL_W-1:0] DWELL_MIN   = 16'd1;
    localparam logic [SEG_W-1:0]   COLON_MASK  = 8'h80;
    localparam logic [EN_W-1:0]    COLON_EN    = 4'h3;
    localparam logic               REG_DWELL   = 1'b0;

    typedef struct packed {
        logic [EN_W-1:0]  en;
        logic [SEG_W-1:0] segs;
        logic             last;
        logic             ovf;
    } fdss_entry_t;

    typedef struct packed {
        logic        full;
        logic        empty;
        fdss_entry_t head;
    } fdss_q_status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_COLON
    } fdss_front_state_t;

    typedef enum logic {
        B_IDLE,
        B_EMIT
    } fdss_back_state_t;

    // 10^e for e = 0..4
    function automatic logic [NUM_W-1:0] pow10(input logic [EXP_W-1:0] e);
        logic [NUM_W-1:0] r;
        case (e)
            3'd0:    r = 14'd1;
            3'd1:    r = 14'd10;
            3'd2:    r = 14'd100;
            3'd3:    r = 14'd1000;
            3'd4:    r = 14'd10000;
            default: r = 14'd1;
        endcase
        return r;
    endfunction

    // segments a..g in bits 0..6
    function automatic logic [6:0] seg_decode(input logic [DIG_W-1:0] d);
        logic [6:0] r;
        case (d)
            4'd0:    r = 7'h3F;
            4'd1:    r = 7'h06;
            4'd2:    r = 7'h5B;
            4'd3:    r = 7'h4F;
            4'd4:    r = 7'h66;
            4'd5:    r = 7'h6D;
            4'd6:    r = 7'h7D;
            4'd7:    r = 7'h07;
            4'd8:    r = 7'h7F;
            4'd9:    r = 7'h6F;
            default: r = 7'h00;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/fdss_fifo.sv
// Short entry queue between the digit front end and the pulse back end.
// Depends on fdss_pkg.
module fdss_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  fdss_pkg::fdss_entry_t  wr_data,
    input  logic                   rd_en,
    output fdss_pkg::fdss_q_status_t status
);

    fdss_pkg::fdss_entry_t             mem_reg [fdss_pkg::QDEPTH];
    logic [fdss_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [fdss_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [fdss_pkg::QCNT_W-1:0]       count_reg;
    logic [fdss_pkg::QCNT_W-1:0]       count_next;
    logic                              do_wr;
    logic                              do_rd;

    assign do_wr = wr_en && !status.full;
    assign do_rd = rd_en && !status.empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 3'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign status.full  = (count_reg == fdss_pkg::QCNT_W'(fdss_pkg::QDEPTH));
    assign status.empty = (count_reg == '0);
    assign status.head  = mem_reg[rd_ptr_reg];

endmodule

// File: rtl/fdss_front.sv
// Front end: takes an item, clamps it, peels decimal digits one subtract per
// cycle and queues one entry per shown digit plus any colon. Depends on fdss_pkg.
module fdss_front #(
    parameter int EFF_DIGITS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [fdss_pkg::NUM_W-1:0]  number,
    input  logic                        show_colon,
    output logic                        busy,
    input  logic                        q_full,
    output logic                        q_push,
    output fdss_pkg::fdss_entry_t       q_entry
);

    localparam logic [fdss_pkg::EXP_W-1:0] TOP_EXP = fdss_pkg::EXP_W'(EFF_DIGITS - 1);
    localparam logic [fdss_pkg::NUM_W-1:0] LIMIT =
        fdss_pkg::pow10(fdss_pkg::EXP_W'(EFF_DIGITS)) - 14'd1;
    localparam logic [fdss_pkg::POS_W-1:0] UNITS_POS = fdss_pkg::POS_W'(EFF_DIGITS - 1);

    fdss_pkg::fdss_front_state_t       state_reg;
    fdss_pkg::fdss_front_state_t       state_next;
    logic [fdss_pkg::NUM_W-1:0]        val_reg;
    logic [fdss_pkg::DIG_W-1:0]        dig_reg;
    logic [fdss_pkg::POS_W-1:0]        pos_reg;
    logic                              lit_reg;
    logic                              ovf_reg;
    logic                              colon_reg;

    logic [fdss_pkg::NUM_W-1:0]        weight;
    logic                              ge;
    logic                              units;
    logic                              shown;
    logic                              accept;
    logic                              digit_done;

    assign weight     = fdss_pkg::pow10(TOP_EXP - {1'b0, pos_reg});
    assign ge         = (val_reg >= weight);
    assign units      = (pos_reg == UNITS_POS);
    assign shown      = units || lit_reg || (dig_reg != '0);
    assign accept     = push && (state_reg == fdss_pkg::F_IDLE);
    // digit finished and either blanked or room to queue it
    assign digit_done = (state_reg == fdss_pkg::F_CONV) && !ge && (!shown || !q_full);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fdss_pkg::F_IDLE:
            begin
                if (push)
                begin
                    state_next = fdss_pkg::F_CONV;
                end
            end
            fdss_pkg::F_CONV:
            begin
                if (digit_done && units)
                begin
                    state_next = colon_reg ? fdss_pkg::F_COLON : fdss_pkg::F_IDLE;
                end
            end
            fdss_pkg::F_COLON:
            begin
                if (!q_full)
                begin
                    state_next = fdss_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = fdss_pkg::F_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        q_push        = 1'b0;
        q_entry.en    = ~(4'b0001 << pos_reg);
        q_entry.segs  = {1'b0, fdss_pkg::seg_decode(dig_reg)};
        q_entry.last  = units && !colon_reg;
        q_entry.ovf   = ovf_reg;
        case (state_reg)
            fdss_pkg::F_IDLE:
            begin
                q_push = 1'b0;
            end
            fdss_pkg::F_CONV:
            begin
                q_push = !ge && shown && !q_full;
            end
            fdss_pkg::F_COLON:
            begin
                q_push       = !q_full;
                q_entry.en   = fdss_pkg::COLON_EN;
                q_entry.segs = fdss_pkg::COLON_MASK;
                q_entry.last = 1'b1;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != fdss_pkg::F_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fdss_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            val_reg   <= (number > LIMIT) ? LIMIT : number;
            ovf_reg   <= (number > LIMIT);
            colon_reg <= show_colon;
            dig_reg   <= '0;
            pos_reg   <= '0;
            lit_reg   <= 1'b0;
        end
        else if ((state_reg == fdss_pkg::F_CONV) && ge)
        begin
            val_reg <= val_reg - weight;
            dig_reg <= dig_reg + 4'd1;
        end
        else if (digit_done)
        begin
            lit_reg <= lit_reg || (dig_reg != '0);
            dig_reg <= '0;
            pos_reg <= pos_reg + 2'd1;
        end
    end

endmodule

// File: rtl/fdss_back.sv
// Back end: expands each queued entry into one-hot segment pulses, paced by
// the dwell count, into a one-deep output register. Depends on fdss_pkg.
`include "four_digit_segment_scan_defines.svh"

module fdss_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [fdss_pkg::DWELL_W-1:0]  dwell,
    input  fdss_pkg::fdss_q_status_t      q_status,
    output logic                          q_pop,
    input  logic                          pop,
    output logic                          empty,
    output logic [fdss_pkg::EN_W-1:0]     digit_enables,
    output logic [fdss_pkg::SEG_W-1:0]    segment_mask,
    output logic                          last_pulse,
    output logic                          overflow
);

    fdss_pkg::fdss_back_state_t        state_reg;
    fdss_pkg::fdss_back_state_t        state_next;
    logic [fdss_pkg::SEG_W-1:0]        mask_reg;
    logic [fdss_pkg::EN_W-1:0]         en_reg;
    logic                              last_reg;
    logic                              ovf_reg;
    logic [fdss_pkg::DWELL_W-1:0]      dwell_cnt_reg;

    logic                              out_valid_reg;
    logic [fdss_pkg::EN_W-1:0]         out_en_reg;
    logic [fdss_pkg::SEG_W-1:0]        out_seg_reg;
    logic                              out_last_reg;
    logic                              out_ovf_reg;

    logic [fdss_pkg::SEG_W-1:0]        low_bit;
    logic [fdss_pkg::SEG_W-1:0]        rest;
    logic                              load;

    assign low_bit = mask_reg & (~mask_reg + 8'd1);
    assign rest    = mask_reg & ~low_bit;
    assign load    = (state_reg == fdss_pkg::B_EMIT) && (dwell_cnt_reg == '0)
                     && (!out_valid_reg || pop);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fdss_pkg::B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = fdss_pkg::B_EMIT;
                end
            end
            fdss_pkg::B_EMIT:
            begin
                if (load && (rest == '0))
                begin
                    state_next = fdss_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = fdss_pkg::B_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        case (state_reg)
            fdss_pkg::B_IDLE: q_pop = !q_status.empty;
            fdss_pkg::B_EMIT: q_pop = 1'b0;
            default:          q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fdss_pkg::B_IDLE;
            mask_reg      <= '0;
            en_reg        <= '0;
            last_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            dwell_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                mask_reg <= q_status.head.segs;
                en_reg   <= q_status.head.en;
                last_reg <= q_status.head.last;
                ovf_reg  <= q_status.head.ovf;
            end
            else if (load)
            begin
                mask_reg <= rest;
            end

            if (load)
            begin
                dwell_cnt_reg <= dwell - 16'd1;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (dwell_cnt_reg != '0)
                begin
                    dwell_cnt_reg <= dwell_cnt_reg - 16'd1;
                end
                if (pop)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_en_reg   <= en_reg;
            out_seg_reg  <= low_bit;
            out_last_reg <= last_reg && (rest == '0);
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign empty         = !out_valid_reg;
    assign digit_enables = out_en_reg;
    assign segment_mask  = out_seg_reg;
    assign last_pulse    = out_last_reg;
    assign overflow      = out_ovf_reg;

    `FDSS_ASSERT_ALWAYS(a_pulse_onehot, out_valid_reg |-> $onehot(out_seg_reg), "pulse not one-hot")
    `FDSS_ASSERT(a_colon_enables, (out_valid_reg && out_seg_reg[7]) |-> (out_en_reg == fdss_pkg::COLON_EN), "colon pulse with wrong enables")
    `FDSS_ASSERT(a_idle_drained, (state_reg == fdss_pkg::B_IDLE) |-> (mask_reg == '0), "idle with segments left")
    `FDSS_ASSERT(a_entry_lit, q_pop |-> (q_status.head.segs != '0), "queued entry has no segments")

endmodule

// File: rtl/four_digit_segment_scan.sv
// First pulse after an item is accepted (back end idle): the front end peels each digit
//   by repeated subtraction, then the entry is written to the queue, popped and loaded.
// Each pulse is paced by dwell_ticks and waits for pop; up to 29 pulses per item.
//   Pulse pacing, not the front end, sets the item rate.
// Reset: rst_n async active low; queues empty, no pulse pending, dwell_ticks = 100.
module four_digit_segment_scan #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fdss_pkg::ADDR_W-1:0]   paddr,
    input  logic [fdss_pkg::DATA_W-1:0]   pwdata,
    output logic [fdss_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // item input
    input  logic                          push,
    output logic                          full,
    input  logic [fdss_pkg::NUM_W-1:0]    number,
    input  logic                          show_colon,
    // pulse output
    output logic                          empty,
    input  logic                          pop,
    output logic [fdss_pkg::EN_W-1:0]     digit_enables,
    output logic [fdss_pkg::SEG_W-1:0]    segment_mask,
    output logic                          last_pulse,
    output logic                          overflow
);

    // Only four digit enables exist, so the digit count saturates to 1..4.
    localparam int EFF_DIGITS = (NUM_DIGITS < 1) ? 1 :
                                (NUM_DIGITS > fdss_pkg::MAX_DIGITS) ? fdss_pkg::MAX_DIGITS :
                                NUM_DIGITS;

    logic [fdss_pkg::DWELL_W-1:0]  dwell_reg;
    logic                          cfg_wr;
    logic                          reg_sel;

    fdss_pkg::fdss_entry_t         q_entry;
    fdss_pkg::fdss_q_status_t      q_status;
    logic                          q_push;
    logic                          q_pop;

    // Register file: a single dwell register at byte address 0. paddr[2] is the
    // register index; writes to any other index are dropped and read back 0.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == fdss_pkg::REG_DWELL);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? {16'd0, dwell_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_reg <= fdss_pkg::DWELL_RESET;
        end
        else if (cfg_wr)
        begin
            // a zero dwell is held as the minimum of one tick
            dwell_reg <= (pwdata[15:0] == '0) ? fdss_pkg::DWELL_MIN : pwdata[15:0];
        end
    end

    // Front end: one item at a time; full stays high until its last entry is queued.
    fdss_front #(
        .EFF_DIGITS (EFF_DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .number     (number),
        .show_colon (show_colon),
        .busy       (full),
        .q_full     (q_status.full),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    // Entry queue decouples digit peeling from pulse pacing.
    fdss_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_entry),
        .rd_en   (q_pop),
        .status  (q_status)
    );

    // Back end: one pulse per lit segment, a..g then colon, each paced by the dwell count.
    fdss_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .dwell         (dwell_reg),
        .q_status      (q_status),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .digit_enables (digit_enables),
        .segment_mask  (segment_mask),
        .last_pulse    (last_pulse),
        .overflow      (overflow)
    );

endmodule

// File: tb/tb_four_digit_segment_scan.sv
// Self-checking testbench for four_digit_segment_scan: queue-style item and pulse ports,
// APB dwell register. Depends on fdss_pkg and the block's RTL only.
// Pulses are predicted per item by a scoreboard class and checked in order.
module tb_four_digit_segment_scan;
    timeunit 1ns;
    timeprecision 1ps;

    // digit count the block is built with; the predictor saturates it as the block does
    localparam int SCAN_DIGITS = 4;

    // register map: index i at byte address 4*i
    localparam logic [fdss_pkg::ADDR_W-1:0] DWELL_ADDR =
        fdss_pkg::ADDR_W'(fdss_pkg::REG_DWELL) << 2;
    localparam logic [fdss_pkg::ADDR_W-1:0] SPARE_ADDR = fdss_pkg::ADDR_W'(4); // index 1

    // watchdog: cycles with no item or pulse accepted. The slowest legal gap is one
    // pulse held for the largest dwell (65535) plus the longest pop stall.
    localparam int unsigned QUIET_LIMIT = 262144;
    localparam int unsigned LONG_HOLD   = 400;   // receiver hold-off to fill the block
    localparam int unsigned END_SETTLE  = 40;

    // ------------------------------------------------------------------
    // Pulse predictor and scoreboard
    // ------------------------------------------------------------------
    class pulse_scoreboard;
        fdss_pkg::fdss_entry_t        pulse_q[$];   // pulses still owed, oldest first
        logic [fdss_pkg::DWELL_W-1:0] dwell;        // shadow of the dwell register
        logic [6:0]                   glyph[10];    // segments a..g per decimal digit
        int unsigned                  n_items, n_clamped, n_colon, n_pulses, n_errors;

        function new();
            dwell = fdss_pkg::DWELL_RESET;
            glyph = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
            n_items = 0;
            n_clamped = 0;
            n_colon = 0;
            n_pulses = 0;
            n_errors = 0;
        endfunction

        function int pending();
            return pulse_q.size();
        endfunction

        function void log_error(string msg);
            n_errors++;
            if (n_errors <= 10)
                $display("[sb] %s", msg);
        endfunction

        // writes to unimplemented indexes are dropped; a zero dwell is stored as one
        function void note_write(logic [fdss_pkg::ADDR_W-1:0] addr,
                                 logic [fdss_pkg::DATA_W-1:0] data);
            if (addr[1:0] == 2'b00
                && (addr >> 2) == fdss_pkg::ADDR_W'(fdss_pkg::REG_DWELL))
                dwell = (data[fdss_pkg::DWELL_W-1:0] == '0) ? fdss_pkg::DWELL_MIN
                                                            : data[fdss_pkg::DWELL_W-1:0];
        endfunction

        function void check_read(logic [fdss_pkg::ADDR_W-1:0] addr,
                                 logic [fdss_pkg::DATA_W-1:0] got);
            logic [fdss_pkg::DATA_W-1:0] want;
            want = fdss_pkg::DATA_W'(dwell);
            if (got !== want)
                log_error($sformatf("read addr %0d: expected %h, got %h", addr, want, got));
        endfunction

        // one item -> list of single-segment pulses, digits left to right, a..g,
        // then the optional colon; the final pulse carries last
        function void note_item(logic [fdss_pkg::NUM_W-1:0] num, logic colon);
            int unsigned           digits, limit, value, weight, pos, s, d;
            logic                  ovf;
            logic [6:0]            lit;
            fdss_pkg::fdss_entry_t e;
            digits = (SCAN_DIGITS < 1) ? 1 :
                     (SCAN_DIGITS > fdss_pkg::MAX_DIGITS) ? fdss_pkg::MAX_DIGITS
                                                          : SCAN_DIGITS;
            limit = 1;
            for (pos = 0; pos < digits; pos++)
                limit *= 10;
            limit -= 1;
            value = num;
            ovf = 1'b0;
            if (value > limit)
            begin
                value = limit;
                ovf = 1'b1;
            end
            weight = (limit + 1) / 10;
            for (pos = 0; pos < digits; pos++)
            begin
                // leading zeros blank; the units digit always shows
                if (pos + 1 == digits || value >= weight)
                begin
                    d = (value / weight) % 10;
                    lit = glyph[d];
                    for (s = 0; s < 7; s++)
                    begin
                        if (lit[s])
                        begin
                            e.en   = ~(fdss_pkg::EN_W'(1) << pos);
                            e.segs = fdss_pkg::SEG_W'(1) << s;
                            e.last = 1'b0;
                            e.ovf  = ovf;
                            pulse_q.push_back(e);
                        end
                    end
                end
                weight /= 10;
                if (weight == 0)
                    weight = 1;
            end
            if (colon)
            begin
                e.en   = fdss_pkg::COLON_EN;
                e.segs = fdss_pkg::COLON_MASK;
                e.last = 1'b0;
                e.ovf  = ovf;
                pulse_q.push_back(e);
                n_colon++;
            end
            e = pulse_q.pop_back();
            e.last = 1'b1;
            pulse_q.push_back(e);
            n_items++;
            if (ovf)
                n_clamped++;
        endfunction

        function void check_pulse(logic [fdss_pkg::EN_W-1:0] en,
                                  logic [fdss_pkg::SEG_W-1:0] segs,
                                  logic last, logic ovf);
            fdss_pkg::fdss_entry_t want;
            n_pulses++;
            if (pulse_q.size() == 0)
            begin
                log_error($sformatf("unexpected pulse en=%h seg=%h last=%b ovf=%b",
                                    en, segs, last, ovf));
                return;
            end
            want = pulse_q.pop_front();
            if (en !== want.en || segs !== want.segs || last !== want.last
                || ovf !== want.ovf)
                log_error($sformatf({"pulse %0d: expected en=%h seg=%h last=%b ovf=%b,",
                                     " got en=%h seg=%h last=%b ovf=%b"},
                                    n_pulses, want.en, want.segs, want.last, want.ovf,
                                    en, segs, last, ovf));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and stimulus signals
    // ------------------------------------------------------------------
    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        psel, penable, pwrite;
    logic [fdss_pkg::ADDR_W-1:0] paddr;
    logic [fdss_pkg::DATA_W-1:0] pwdata;
    logic [fdss_pkg::DATA_W-1:0] prdata;
    logic                        pready;
    logic                        push, full;
    logic [fdss_pkg::NUM_W-1:0]  number;
    logic                        show_colon;
    logic                        empty, pop;
    logic [fdss_pkg::EN_W-1:0]   digit_enables;
    logic [fdss_pkg::SEG_W-1:0]  segment_mask;
    logic                        last_pulse, overflow;

    pulse_scoreboard sb = new();

    // knobs shared between the sender, receiver and the phase sequence
    bit          tx_idle;        // sender inserts random gaps
    bit          rx_idle;        // receiver inserts random pop stalls
    bit          hold_req;       // one-shot request for a long pop hold-off
    int unsigned quiet_cycles;
    int unsigned stall_cycles;   // cycles the input sat blocked on full

    four_digit_segment_scan #(
        .NUM_DIGITS(SCAN_DIGITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .number        (number),
        .show_colon    (show_colon),
        .empty         (empty),
        .pop           (pop),
        .digit_enables (digit_enables),
        .segment_mask  (segment_mask),
        .last_pulse    (last_pulse),
        .overflow      (overflow)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, where stimulus
    // driven on the falling edge is stable. Items are predicted the
    // moment they are accepted, so expectations always lead the pulses.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (push && !full)
                sb.note_item(number, show_colon);
            if (pop && !empty)
                sb.check_pulse(digit_enables, segment_mask, last_pulse, overflow);
            if (push && full)
                stall_cycles++;
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[tb] watchdog: no handshake for %0d cycles, %0d pulses owed",
                         quiet_cycles, sb.pending());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: pop decided on every falling edge. Short stalls are common,
    // long ones rare; a hold-off request freezes pop, counting down LONG_HOLD,
    // while the sender keeps offering items.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stall;
        stall = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = LONG_HOLD;
            end
            else if (stall == 0 && rx_idle && $urandom_range(0, 3) == 0)
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 3);
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
                pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Register access: setup cycle, then access cycle until pready.
    // ------------------------------------------------------------------
    task automatic reg_access(input bit is_write, input logic [fdss_pkg::ADDR_W-1:0] addr,
                              input logic [fdss_pkg::DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (is_write)
            sb.note_write(addr, data);
        else
            sb.check_read(addr, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write the dwell and read it back
    task automatic set_dwell(input logic [fdss_pkg::DATA_W-1:0] data);
        reg_access(1'b1, DWELL_ADDR, data);
        reg_access(1'b0, DWELL_ADDR, '0);
    endtask

    // ------------------------------------------------------------------
    // Sender: push stays high across back-to-back items and only drops
    // for a gap, so each falling edge assigns it at most once.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [fdss_pkg::NUM_W-1:0] num, input logic colon);
        int unsigned gap;
        gap = 0;
        if (tx_idle && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                              : $urandom_range(1, 3);
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push       <= 1'b1;
        number     <= num;
        show_colon <= colon;
        do
            @(posedge clk);
        while (full);
    endtask

    // drop push and wait until every owed pulse has been popped
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // mostly in-range values, with small values, clamped values, round
    // numbers (trailing zero digits) and the full 14-bit range mixed in
    function automatic logic [fdss_pkg::NUM_W-1:0] rand_number();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1:    return fdss_pkg::NUM_W'($urandom_range(0, 99));
            2:       return fdss_pkg::NUM_W'($urandom_range(10000, 16383));
            3:       return fdss_pkg::NUM_W'($urandom_range(0, 16383));
            4:       return fdss_pkg::NUM_W'($urandom_range(1, 9)
                                             * (10 ** $urandom_range(0, 3)));
            default: return fdss_pkg::NUM_W'($urandom_range(0, 9999));
        endcase
    endfunction

    task automatic send_random(input int unsigned count, input bit with_drain);
        repeat (count)
        begin
            if (with_drain && $urandom_range(0, 7) == 0)
                drain();
            send_item(rand_number(), 1'($urandom_range(0, 1)));
        end
    endtask

    // directed items: zero (units digit kept), single digits with fewest and
    // most segments, inner and trailing zeros, every decimal digit, the
    // clamp boundary, the all-ones input, and the longest pass (8888 + colon)
    int unsigned dir_num [0:24] = '{0, 0, 8, 1, 7, 10, 100, 1000, 1001, 9999,
                                    9999, 10000, 10000, 16383, 8888, 1234, 5678, 9090,
                                    4096, 2048, 8191, 12345, 9998, 6, 23};
    bit          dir_col [0:24] = '{0, 1, 0, 0, 1, 0, 0, 0, 1, 0,
                                    1, 0, 1, 0, 1, 1, 0, 0,
                                    1, 0, 0, 1, 0, 0, 1};

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [fdss_pkg::DATA_W-1:0] wd;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        push         = 1'b0;
        number       = '0;
        show_colon   = 1'b0;
        tx_idle      = 1'b0;
        rx_idle      = 1'b1;
        hold_req     = 1'b0;
        quiet_cycles = 0;
        stall_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset value of the dwell, then directed items at that dwell
        reg_access(1'b0, DWELL_ADDR, '0);
        for (int i = 0; i < 25; i++)
            send_item(fdss_pkg::NUM_W'(dir_num[i]), dir_col[i]);
        drain();

        // zero dwell is stored as the minimum; sender gaps, receiver always ready
        set_dwell('0);
        tx_idle = 1'b1;
        rx_idle = 1'b0;
        send_random(60, 1'b0);
        drain();

        // write to an unimplemented index must leave the dwell alone
        reg_access(1'b1, SPARE_ADDR, $urandom());
        reg_access(1'b0, DWELL_ADDR, '0);

        // short dwell with junk in the upper data bits; a long pop hold-off
        // while items keep coming back to back, so the input backs up
        wd = $urandom();
        wd[fdss_pkg::DWELL_W-1:0] = fdss_pkg::DWELL_W'($urandom_range(2, 6));
        set_dwell(wd);
        tx_idle = 1'b0;
        hold_req = 1'b1;
        send_random(20, 1'b0);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_random(50, 1'b0);
        drain();

        // largest dwell: one short pass (digit 1, two pulses)
        set_dwell('1);
        send_item(fdss_pkg::NUM_W'(1), 1'b0);
        drain();

        // back to a short dwell; the sender now and then waits for a full drain
        set_dwell(fdss_pkg::DATA_W'(3));
        send_random(70, 1'b1);
        drain();

        // leave room for any stray pulse after the last expected one
        repeat (END_SETTLE + 2 * sb.dwell) @(posedge clk);
        if (sb.pending() != 0)
            sb.log_error($sformatf("%0d pulses never arrived", sb.pending()));

        $display("[tb] covered %0d items (%0d clamped, %0d with colon), %0d pulses checked",
                 sb.n_items, sb.n_clamped, sb.n_colon, sb.n_pulses);
        $display("[tb] dwell 100, 1, %0d, 65535 and 3; input blocked for %0d cycles; %0d errors",
                 wd[fdss_pkg::DWELL_W-1:0], stall_cycles, sb.n_errors);
        if (sb.n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
